// File: rtl/irac_pkg.sv
// ----------------------------------------------------------------------------
// irac_pkg
// Shared constants and helpers for the integer to radix ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package irac_pkg;

  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned IN_W           = 32;
  localparam int unsigned RADIX_W        = 6;
  localparam int unsigned CHAR_W         = 7;
  localparam int unsigned OUT_TDATA_W    = 8;
  localparam int unsigned STEP_BITS      = 8;

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] BASE_MIN    = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] BASE_MAX    = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] BASE_DEC    = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] DIGIT_MAX_DEC = RADIX_W'(9);

  localparam logic [CHAR_W-1:0] CHAR_ZERO     = CHAR_W'(8'h30);
  localparam logic [CHAR_W-1:0] CHAR_ALPHA_OF = CHAR_W'(8'h61 - 8'd10);
  localparam logic [CHAR_W-1:0] CHAR_MINUS    = CHAR_W'(8'h2d);

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    if (d <= DIGIT_MAX_DEC) begin
      return CHAR_ZERO + CHAR_W'(d);
    end
    return CHAR_ALPHA_OF + CHAR_W'(d);
  endfunction

endpackage

`default_nettype wire

// File: rtl/irac_divstep.sv
// ----------------------------------------------------------------------------
// irac_divstep
// Shared divide unit: several restoring long-division steps by the base.
// ----------------------------------------------------------------------------
`default_nettype none

module irac_divstep (
  input  wire logic [irac_pkg::RADIX_W-1:0]   base_i,
  input  wire logic [irac_pkg::RADIX_W-1:0]   rem_i,
  input  wire logic [irac_pkg::STEP_BITS-1:0] bits_i,
  output logic      [irac_pkg::STEP_BITS-1:0] quo_o,
  output logic      [irac_pkg::RADIX_W-1:0]   rem_o
);
  import irac_pkg::*;

  logic [RADIX_W:0]   t;
  logic [RADIX_W-1:0] r;

  // remainder stays below base, so {r, bit} fits in RADIX_W+1 bits
  always_comb begin
    r = rem_i;
    t = '0;
    quo_o = '0;
    for (int i = STEP_BITS - 1; i >= 0; i--) begin
      t = {r, bits_i[i]};
      if (t >= {1'b0, base_i}) begin
        quo_o[i] = 1'b1;
        t = t - {1'b0, base_i};
      end
      r = t[RADIX_W-1:0];
    end
    rem_o = r;
  end

endmodule

`default_nettype wire

// File: rtl/irac_digit_ram.sv
// ----------------------------------------------------------------------------
// irac_digit_ram
// Digit store, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module irac_digit_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  wire logic                           clk_i,
  input  wire logic                           we_i,
  input  wire logic [AW-1:0]                  waddr_i,
  input  wire logic [irac_pkg::RADIX_W-1:0]   wdata_i,
  input  wire logic                           re_i,
  input  wire logic [AW-1:0]                  raddr_i,
  output logic      [irac_pkg::RADIX_W-1:0]   rdata_o
);
  import irac_pkg::*;

  logic [RADIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/integer_to_radix_ascii.sv
// ----------------------------------------------------------------------------
// integer_to_radix_ascii
// Converts a signed integer to ASCII text in a programmable base, MSD first.
// ----------------------------------------------------------------------------
// Sequence: accept in S_IDLE, then per digit the shared divide unit in S_DIV
//   takes the magnitude STEP_BITS bits at a time; digits are then emitted
//   MSD first through S_READ and S_LOAD, after a sign through S_SIGN.
// Flow: input is not ready while an item is divided or emitted.
// Reset: radix returns to 10, sequencer idle, no output pending.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_radix_ascii #(
  parameter int unsigned VALUE_BITS = irac_pkg::VALUE_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [irac_pkg::RADIX_W-1:0]      cfg_wdata_i,   // radix
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  input  wire logic [irac_pkg::IN_W-1:0]         s_axis_tdata_i, // [31:0] number_in
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  output logic      [irac_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o, // [6:0] char_out
  output logic                                   m_axis_tlast_o  // last_char
);
  import irac_pkg::*;

  localparam int unsigned CHUNKS = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int unsigned PAD_W  = CHUNKS * STEP_BITS;
  localparam int unsigned CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int unsigned AW     = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int unsigned EXT_W  = (VALUE_BITS > IN_W) ? VALUE_BITS : IN_W;

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_SIGN, S_READ, S_LOAD} state_e;

  state_e             state_q;
  logic [RADIX_W-1:0] radix_q;
  logic [RADIX_W-1:0] base_q;
  logic [RADIX_W-1:0] rem_q;
  logic [PAD_W-1:0]   mag_q;
  logic [CW-1:0]      cnt_q;
  logic [AW-1:0]      wr_ptr_q;
  logic [AW-1:0]      rd_ptr_q;
  logic               sign_q;
  logic               out_valid_q;
  logic [CHAR_W-1:0]  out_char_q;
  logic               out_last_q;

  logic [RADIX_W-1:0]    base_eff;
  logic [EXT_W-1:0]      ext;
  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag;
  logic                  neg;
  logic                  in_acc;
  logic                  cnt_last;
  logic                  out_free;
  logic                  out_load;
  logic [STEP_BITS-1:0]  quo;
  logic [RADIX_W-1:0]    rem_nx;
  logic [PAD_W-1:0]      mag_nx;
  logic [RADIX_W-1:0]    rd_digit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (cfg_we_i) begin
      radix_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (radix_q < BASE_MIN) begin
      base_eff = BASE_MIN;
    end else if (radix_q > BASE_MAX) begin
      base_eff = BASE_MAX;
    end else begin
      base_eff = radix_q;
    end
  end

  assign ext = EXT_W'($signed(s_axis_tdata_i));
  assign raw = ext[VALUE_BITS-1:0];
  assign neg = raw[VALUE_BITS-1];
  assign mag = neg ? (VALUE_BITS'(0) - raw) : raw;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign cnt_last        = (cnt_q == CW'(CHUNKS - 1));
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign out_load        = ((state_q == S_SIGN) || (state_q == S_LOAD)) && out_free;

  irac_divstep u_div (
    .base_i (base_q),
    .rem_i  (rem_q),
    .bits_i (mag_q[PAD_W-1 -: STEP_BITS]),
    .quo_o  (quo),
    .rem_o  (rem_nx)
  );

  // quotient bits shift in at the bottom as dividend bits leave the top
  if (CHUNKS > 1) begin : g_shift
    assign mag_nx = {mag_q[PAD_W-STEP_BITS-1:0], quo};
  end else begin : g_single
    assign mag_nx = quo;
  end

  irac_digit_ram #(
    .DEPTH (VALUE_BITS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    ((state_q == S_DIV) && cnt_last),
    .waddr_i (wr_ptr_q),
    .wdata_i (rem_nx),
    .re_i    (state_q == S_READ),
    .raddr_i (rd_ptr_q),
    .rdata_o (rd_digit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_q      <= BASE_DEC;
      rem_q       <= '0;
      mag_q       <= '0;
      cnt_q       <= '0;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      sign_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            mag_q    <= PAD_W'(mag);
            base_q   <= base_eff;
            sign_q   <= neg && (base_eff == BASE_DEC);
            rem_q    <= '0;
            cnt_q    <= '0;
            wr_ptr_q <= '0;
            state_q  <= S_DIV;
          end
        end
        S_DIV: begin
          mag_q <= mag_nx;
          if (cnt_last) begin
            cnt_q <= '0;
            rem_q <= '0;
            if (mag_nx == '0) begin
              rd_ptr_q <= wr_ptr_q;
              state_q  <= sign_q ? S_SIGN : S_READ;
            end else begin
              wr_ptr_q <= wr_ptr_q + 1'b1;
            end
          end else begin
            cnt_q <= cnt_q + 1'b1;
            rem_q <= rem_nx;
          end
        end
        S_SIGN: begin
          if (out_free) begin
            out_char_q  <= CHAR_MINUS;
            out_last_q  <= 1'b0;
            state_q     <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          if (out_free) begin
            out_char_q  <= digit_char(rd_digit);
            out_last_q  <= (rd_ptr_q == '0);
            if (rd_ptr_q == '0) begin
              state_q <= S_IDLE;
            end else begin
              rd_ptr_q <= rd_ptr_q - 1'b1;
              state_q  <= S_READ;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(out_char_q);
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire

// File: bench/integer_to_radix_ascii_chk.sv
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_chk
// Watches the config port and both streams of the radix converter, builds the
// expected character string for every accepted integer under the radix in
// force at that time, and checks the output stream item by item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_to_radix_ascii_chk
  import irac_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [RADIX_W-1:0]     cfg_wdata_i,
  input  logic                   s_axis_tvalid_i,
  input  logic                   s_axis_tready_i,
  input  logic [IN_W-1:0]        s_axis_tdata_i,   // [31:0] number_in
  input  logic                   m_axis_tvalid_i,
  input  logic                   m_axis_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata_i,   // [6:0] char_out
  input  logic                   m_axis_tlast_i,   // last_char
  output int                     fail_count_o,
  output int                     pending_o,
  output int                     chars_o
);

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  text_char_t         text_q[$];
  logic [RADIX_W-1:0] radix_q;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    chars_o      = 0;
  end

  // Expected text of one integer, appended to the queue.
  function automatic void push_text(input logic [IN_W-1:0] number,
                                    input logic [RADIX_W-1:0] radix);
    logic [RADIX_W-1:0] base;
    logic [IN_W-1:0]    divisor;
    logic [IN_W-1:0]    mag;
    logic [IN_W-1:0]    digit;
    logic               negative;
    logic [CHAR_W-1:0]  digit_chars[$];
    text_char_t         tc;
    base = (radix < BASE_MIN) ? BASE_MIN : (radix > BASE_MAX) ? BASE_MAX : radix;
    divisor = IN_W'(base);
    negative = number[IN_W-1];
    mag = negative ? -number : number;
    do begin
      digit = mag % divisor;
      if (digit <= IN_W'(DIGIT_MAX_DEC)) begin
        digit_chars.push_front(CHAR_ZERO + CHAR_W'(digit));
      end else begin
        digit_chars.push_front(CHAR_ALPHA_OF + CHAR_W'(digit));
      end
      mag = mag / divisor;
    end while (mag != 0);
    if (negative && base == BASE_DEC) begin
      tc.ch = CHAR_MINUS;
      tc.last = 1'b0;
      text_q.push_back(tc);
    end
    foreach (digit_chars[i]) begin
      tc.ch = digit_chars[i];
      tc.last = (i == digit_chars.size() - 1);
      text_q.push_back(tc);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    text_char_t want;
    if (!rst_ni) begin
      radix_q = RADIX_RESET;
      text_q.delete();
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        chars_o = chars_o + 1;
        if (text_q.size() == 0) begin
          $error("char_out 0x%0h arrived with no item pending", m_axis_tdata_i);
          fail_count_o = fail_count_o + 1;
        end else begin
          want = text_q.pop_front();
          if (m_axis_tdata_i[CHAR_W-1:0] !== want.ch) begin
            $error("char_out: expected 0x%0h, got 0x%0h", want.ch,
                   m_axis_tdata_i[CHAR_W-1:0]);
            fail_count_o = fail_count_o + 1;
          end
          if (m_axis_tlast_i !== want.last) begin
            $error("last_char: expected %0b, got %0b", want.last, m_axis_tlast_i);
            fail_count_o = fail_count_o + 1;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        push_text(s_axis_tdata_i, radix_q);
      end
      if (cfg_we_i) begin
        radix_q = cfg_wdata_i;
      end
    end
    pending_o = text_q.size();
  end

endmodule

// File: bench/integer_to_radix_ascii_tb.sv
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_tb
// Drives integers into the radix converter across a series of radix settings,
// including out-of-range writes that saturate, with random gaps on both
// streams and one long output stall. The checker module judges every item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_to_radix_ascii_tb;
  import irac_pkg::*;

  localparam int ITEMS_PER_PHASE = 34;
  localparam int NUM_PHASES      = 13;
  localparam int FLOOD_PHASE     = 7;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 16;
  localparam int CYCLE_LIMIT     = 3_000_000;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [RADIX_W-1:0]     cfg_wdata_i;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [IN_W-1:0]        s_axis_tdata_i;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   m_axis_tlast_o;

  int fail_count;
  int pending;
  int chars_seen;
  int cycles = 0;
  int items_sent = 0;
  int radix_writes = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit flood = 1'b0;

  integer_to_radix_ascii dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  integer_to_radix_ascii_chk u_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tlast_i  (m_axis_tlast_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .chars_o         (chars_seen)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters outstanding", cycles, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [IN_W-1:0] random_number();
    logic [IN_W-1:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom;
      2: v = $urandom_range(0, 40);
      3: v = -IN_W'($urandom_range(1, 40));
      4: v = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 2)
                                  : 32'h7fff_ffff - $urandom_range(0, 2);
      default: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) begin
          v = -v;
        end
      end
    endcase
    return v;
  endfunction

  // Called and returns at a falling edge.
  task automatic send_number(input logic [IN_W-1:0] value);
    int gap;
    gap = tx_idle ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= value;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    radix_writes++;
    @(negedge clk_i);
  endtask

  // Output side: random stalls per item, one long hold-off in the flood phase.
  initial begin : receiver
    int  w;
    bit  held;
    held = 1'b0;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (flood && !held) begin
        held = 1'b1;
        w = HOLD_CYCLES;
      end else begin
        w = rx_idle ? $urandom_range(0, 14) : 0;
      end
      if (w > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (w) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    logic [IN_W-1:0]    directed[$];
    logic [RADIX_W-1:0] radix_plan[NUM_PHASES];
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    directed = '{32'd0, 32'd1, 32'hffff_ffff, 32'd9, 32'd10, -32'd10, 32'd35, 32'd36,
                 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 32'd100, 32'd1000000000,
                 -32'd999999999, 32'h5555_5555, 32'haaaa_aaaa, 32'hffff_fffe,
                 32'd12345, -32'd7, 32'd255, 32'd65535};
    radix_plan = '{6'd2, 6'd16, 6'd36, 6'd0, 6'd1, 6'd37, 6'd63, 6'd10, 6'd8, 6'd7,
                   6'd35, 6'd0, 6'd0};
    radix_plan[11] = $urandom_range(3, 34);
    radix_plan[12] = $urandom_range(0, 63);
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset radix (base ten) with edge values
    foreach (directed[i]) send_number(directed[i]);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_radix(radix_plan[p]);
      tx_idle = (p % 3 != 1) && (p != FLOOD_PHASE);
      rx_idle = (p % 4 != 2);
      flood   = (p == FLOOD_PHASE);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_number(random_number());
      drain();
      flood = 1'b0;
    end

    $display("Converted %0d integers under %0d radix settings, %0d characters checked.",
             items_sent, radix_writes + 1, chars_seen);
    $display("Bases 2..36 with saturating writes of 0, 1, 37 and 63, plus a %0d-cycle stall.",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
